FILE: rtl/msd_pkg.sv
`default_nettype none

package msd_pkg;

  // field widths
  localparam int OP_W    = 1;
  localparam int BYTE_W  = 8;
  localparam int ZP_W    = 9;
  localparam int SCALE_W = 16;
  localparam int CUT_W   = 17;
  localparam int WS_W    = 9;
  localparam int PROB_W  = 26;
  localparam int DIFF_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // default ring depth
  localparam int WINDOW_DEPTH_DEF = 256;

  // register reset values
  localparam logic              SIGNED_RST = 1'b1;
  localparam logic [ZP_W-1:0]    ZP_RST     = 9'h180;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 16'd256;
  localparam logic [CUT_W-1:0]   CUT_RST    = 17'd32768;
  localparam logic [WS_W-1:0]    WS_RST     = 9'd5;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_SIGNED = 3'd0,
    REG_ZERO_POINT    = 3'd1,
    REG_SCALE         = 3'd2,
    REG_CUTOFF        = 3'd3,
    REG_WINDOW_SIZE   = 3'd4
  } reg_idx_t;

  // request operations
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // dequantisation settings used by the front end
  typedef struct packed {
    logic               signed_mode;
    logic [ZP_W-1:0]    zp_value;
    logic [SCALE_W-1:0] scale;
  } fcfg_t;

  // window settings used by the back end
  typedef struct packed {
    logic [CUT_W-1:0] cutoff;
    logic [WS_W-1:0]  window_size;
  } bcfg_t;

  // one classified request between front and back
  typedef struct packed {
    op_t                      op;
    logic signed [PROB_W-1:0] prob;
  } entry_t;

  // window size with zero taken as one and the ring depth as ceiling
  function automatic int clamp_window(logic [WS_W-1:0] ws, int depth);
    if (ws == '0) begin
      return 1;
    end
    if (int'(ws) > depth) begin
      return depth;
    end
    return int'(ws);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/moving_average_score_detector_top.sv
// channel   | ports                                         | direction
// ----------+-----------------------------------------------+----------
// in        | in_valid, in_ready, in_operation, in_score_byte | request in
// out       | out_valid, out_ready, out_detected,           | result out
//           | out_window_full, out_probability              |
// cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data     | register write
//
// one request per cycle sustained while out_ready is high; each request gives one result
// result path: queue write on accept, then ring update and output register on pop
// the ring read-modify-write and running sum update are registered in the back end
// rst_n is synchronous; the ring needs no clearing pass, only control and sum registers are reset
// a stalled output holds its result while the two-entry queue takes up to two more requests

`default_nettype none

module moving_average_score_detector_top import msd_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_operation,
  input  wire logic [BYTE_W-1:0]     in_score_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_detected,
  output logic                       out_window_full,
  output logic signed [PROB_W-1:0]   out_probability,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic               signed_r;
  logic [ZP_W-1:0]    zp_r;
  logic [SCALE_W-1:0] scale_r;
  logic [CUT_W-1:0]   cutoff_r;
  logic [WS_W-1:0]    ws_r;

  fcfg_t  fcfg;
  bcfg_t  bcfg;
  entry_t front_entry;
  entry_t q_head;
  logic   q_not_empty;
  logic   q_pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_r <= SIGNED_RST;
      zp_r     <= ZP_RST;
      scale_r  <= SCALE_RST;
      cutoff_r <= CUT_RST;
      ws_r     <= WS_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_OUTPUT_SIGNED: signed_r <= cfg_data[0];
        REG_ZERO_POINT:    zp_r     <= cfg_data[ZP_W-1:0];
        REG_SCALE:         scale_r  <= cfg_data[SCALE_W-1:0];
        REG_CUTOFF:        cutoff_r <= cfg_data[CUT_W-1:0];
        REG_WINDOW_SIZE:   ws_r     <= cfg_data[WS_W-1:0];
        default: ;
      endcase
    end
  end

  assign fcfg = '{signed_mode: signed_r, zp_value: zp_r, scale: scale_r};
  assign bcfg = '{cutoff: cutoff_r, window_size: ws_r};

  // front end: decode and dequantise
  msd_front u_front (
    .in_operation  (in_operation),
    .in_score_byte (in_score_byte),
    .cfg           (fcfg),
    .entry         (front_entry)
  );

  // queue between front and back
  msd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_entry (front_entry),
    .not_full   (in_ready),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // back end: ring, running sum and detection
  msd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (bcfg),
    .q_valid         (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_detected    (out_detected),
    .out_window_full (out_window_full),
    .out_probability (out_probability)
  );

endmodule

`default_nettype wire

FILE: rtl/msd_front.sv
`default_nettype none

module msd_front import msd_pkg::*; (
  input  wire logic              in_operation,
  input  wire logic [BYTE_W-1:0] in_score_byte,
  input  wire fcfg_t             cfg,
  output entry_t                 entry
);

  logic signed [DIFF_W-1:0]    q;
  logic signed [DIFF_W-1:0]    zp;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [SCALE_W:0]     scale_s;
  logic signed [DIFF_W+SCALE_W:0] product;

  // raw byte as int8 or uint8
  always_comb begin
    if (cfg.signed_mode) begin
      q = DIFF_W'($signed(in_score_byte));
    end else begin
      q = $signed(DIFF_W'(in_score_byte));
    end
  end

  // zero point removal and scaling
  assign zp      = DIFF_W'($signed(cfg.zp_value));
  assign diff    = q - zp;
  assign scale_s = $signed({1'b0, cfg.scale});
  assign product = diff * scale_s;

  // clear carries a zero probability
  always_comb begin
    entry.op = op_t'(in_operation);
    if (entry.op == OP_CLEAR) begin
      entry.prob = '0;
    end else begin
      entry.prob = product[PROB_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/msd_queue.sv
`default_nettype none

module msd_queue import msd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        not_full,
  input  wire logic   pop,
  output logic        not_empty,
  output entry_t      head
);

  entry_t     ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign not_full  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = ent_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

  // occupancy stays within two entries
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  // pointers differ exactly when one entry is held
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) == (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

FILE: rtl/msd_back.sv
`default_nettype none

module msd_back import msd_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bcfg_t              cfg,
  input  wire logic               q_valid,
  input  wire entry_t             q_head,
  output logic                    q_pop,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_detected,
  output logic                    out_window_full,
  output logic signed [PROB_W-1:0] out_probability
);

  localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = PROB_W + CW;
  localparam int THR_W = CUT_W + CW;
  localparam logic [CW-1:0]    W_RST   = CW'(clamp_window(WS_RST, WINDOW_DEPTH));
  localparam logic [THR_W-1:0] THR_RST = THR_W'(CUT_RST) * THR_W'(W_RST);

  // ring of recent probabilities
  logic signed [PROB_W-1:0] ring_mem [WINDOW_DEPTH];
  logic signed [PROB_W-1:0] oldest_r;

  logic [AW-1:0]           wp_r, wp_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [CW-1:0]           w_r, w_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [THR_W-1:0]        thr_r, thr_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     det_r, det_nxt;
  logic                     full_r, full_nxt;
  logic signed [PROB_W-1:0] prob_r, prob_nxt;

  logic                     is_clear, do_push, was_full, now_full;
  logic signed [SUM_W-1:0]  old_term;

  // take the queue head whenever the output register is free or draining
  assign q_pop    = q_valid && (!out_valid_r || out_ready);
  assign is_clear = (q_head.op == OP_CLEAR);
  assign do_push  = q_pop && !is_clear;

  // window update for one request
  always_comb begin
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    w_nxt         = w_r;
    sum_nxt       = sum_r;
    det_nxt       = det_r;
    full_nxt      = full_r;
    prob_nxt      = prob_r;
    out_valid_nxt = out_valid_r && !out_ready;
    was_full      = (fill_r == w_r);
    old_term      = was_full ? SUM_W'(oldest_r) : '0;
    now_full      = was_full || (fill_r + CW'(1) == w_r);
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      if (is_clear) begin
        wp_nxt   = '0;
        fill_nxt = '0;
        sum_nxt  = '0;
        w_nxt    = CW'(clamp_window(cfg.window_size, WINDOW_DEPTH));
        det_nxt  = 1'b0;
        full_nxt = 1'b0;
        prob_nxt = '0;
      end else begin
        sum_nxt  = sum_r + (SUM_W'(q_head.prob) - old_term);
        wp_nxt   = (CW'(wp_r) + CW'(1) >= w_r) ? '0 : wp_r + AW'(1);
        fill_nxt = was_full ? fill_r : fill_r + CW'(1);
        full_nxt = now_full;
        det_nxt  = now_full && (sum_nxt > $signed(SUM_W'(thr_r)));
        prob_nxt = q_head.prob;
      end
    end
    thr_nxt = THR_W'(cfg.cutoff) * THR_W'(w_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      fill_r      <= '0;
      w_r         <= W_RST;
      sum_r       <= '0;
      thr_r       <= THR_RST;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      w_r         <= w_nxt;
      sum_r       <= sum_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    det_r  <= det_nxt;
    full_r <= full_nxt;
    prob_r <= prob_nxt;
  end

  // ring write at the pointer, registered read of the next oldest entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      ring_mem[wp_r] <= q_head.prob;
      if (wp_nxt == wp_r) begin
        oldest_r <= q_head.prob;
      end else begin
        oldest_r <= ring_mem[wp_nxt];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_detected    = det_r;
  assign out_window_full = full_r;
  assign out_probability = prob_r;

  // fill level never exceeds the active window
  a_fill_le_w: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= w_r)
    else $error("fill count above window");

  // write pointer stays inside the active window
  a_wp_lt_w: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(wp_r) < w_r)
    else $error("write pointer outside window");

  // a clear empties the window and the sum
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && is_clear) |=> (fill_r == '0 && sum_r == '0 && wp_r == '0))
    else $error("clear left window state behind");

  // detection only on a full window
  a_det_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && det_r) |-> full_r)
    else $error("detection without full window");

endmodule

`default_nettype wire

FILE: dv/tb_moving_average_score_detector_top.sv
`default_nettype none

module tb_moving_average_score_detector_top;
  import msd_pkg::*;

  localparam int PIPE_LATENCY = 2;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int PRINT_LIMIT  = 100;

  // expected result of one request
  typedef struct packed {
    logic                     detected;
    logic                     window_full;
    logic signed [PROB_W-1:0] probability;
  } score_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_operation;
  logic [BYTE_W-1:0]     in_score_byte;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_detected;
  logic                  out_window_full;
  logic signed [PROB_W-1:0] out_probability;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the registers
  logic               sign_mode;
  logic [ZP_W-1:0]    zp_setting;
  logic [SCALE_W-1:0] scale_q16;
  logic [CUT_W-1:0]   mean_cutoff;
  logic [WS_W-1:0]    window_reg;

  // predictor copy of the window
  longint prob_history [WINDOW_DEPTH_DEF];
  int     hist_ptr;
  int     hist_fill;
  int     window_len;
  longint prob_sum;

  score_result_t pending_scores[$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int n_push;
  int n_clear;
  int n_detect;
  int n_reg_writes;
  int widest_window;

  moving_average_score_detector_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_score_byte   (in_score_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_detected    (out_detected),
    .out_window_full (out_window_full),
    .out_probability (out_probability),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // empty the window and latch the window length
  function automatic void restart_window();
    hist_ptr  = 0;
    hist_fill = 0;
    prob_sum  = 0;
    if (window_reg == '0) begin
      window_len = 1;
    end else if (int'(window_reg) > WINDOW_DEPTH_DEF) begin
      window_len = WINDOW_DEPTH_DEF;
    end else begin
      window_len = int'(window_reg);
    end
    if (window_len > widest_window) begin
      widest_window = window_len;
    end
  endfunction

  // restart on a clear; else dequantise, update the ring and compare the sum with the scaled cutoff
  function automatic score_result_t predict_score_result(op_t op, logic [BYTE_W-1:0] raw);
    score_result_t r;
    longint        q;
    longint        zp;
    longint        prob;
    r = '0;
    if (op == OP_CLEAR) begin
      restart_window();
      return r;
    end
    q = longint'(raw);
    if (sign_mode && raw[BYTE_W-1]) begin
      q -= 256;
    end
    zp   = longint'($signed(zp_setting));
    prob = (q - zp) * longint'(scale_q16);
    if (hist_ptr >= window_len) begin
      hist_ptr = 0;
    end
    if (hist_fill >= window_len) begin
      prob_sum -= prob_history[hist_ptr];
    end
    prob_sum += prob;
    prob_history[hist_ptr] = prob;
    hist_ptr = (hist_ptr + 1 >= window_len) ? 0 : hist_ptr + 1;
    if (hist_fill < window_len) begin
      hist_fill++;
    end
    r.window_full = (hist_fill >= window_len);
    r.detected    = r.window_full && (prob_sum > longint'(mean_cutoff) * window_len);
    r.probability = prob[PROB_W-1:0];
    return r;
  endfunction

  // send one request with random gaps in front of it
  task automatic send_request(op_t op, logic [BYTE_W-1:0] raw);
    score_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_score_byte <= raw;
    do @(posedge clk); while (!in_ready);
    r = predict_score_result(op, raw);
    pending_scores.insert(pending_scores.size(), r);
    if (op == OP_CLEAR) begin
      n_clear++;
    end else begin
      n_push++;
    end
    if (r.detected) begin
      n_detect++;
    end
  endtask

  // hold off requests until every result is back
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (reg_idx_t'(idx))
      REG_OUTPUT_SIGNED: sign_mode   = data[0];
      REG_ZERO_POINT:    zp_setting  = data[ZP_W-1:0];
      REG_SCALE:         scale_q16   = data[SCALE_W-1:0];
      REG_CUTOFF:        mean_cutoff = data[CUT_W-1:0];
      REG_WINDOW_SIZE:   window_reg  = data[WS_W-1:0];
      default: ;
    endcase
    n_reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin : check_result
    score_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_scores[0];
        pending_scores.delete(0);
        if (out_detected !== want.detected) begin
          report_mismatch($sformatf("detected %b, expected %b", out_detected, want.detected));
        end
        if (out_window_full !== want.window_full) begin
          report_mismatch($sformatf("window_full %b, expected %b",
                                    out_window_full, want.window_full));
        end
        if (out_probability !== want.probability) begin
          report_mismatch($sformatf("probability %0d, expected %0d",
                                    out_probability, want.probability));
        end
      end
    end
  end

  // byte extremes with the reset settings, filling and wrapping a window of five
  task automatic test_reset_defaults();
    send_request(OP_PUSH, 8'h00);
    send_request(OP_PUSH, 8'h7F);
    send_request(OP_PUSH, 8'h80);
    send_request(OP_PUSH, 8'hFF);
    send_request(OP_PUSH, 8'h7F);
    send_request(OP_PUSH, 8'h7F);
  endtask

  // clear on a full and on an empty window
  task automatic test_clear_window();
    send_request(OP_CLEAR, BYTE_W'($urandom));
    send_request(OP_CLEAR, BYTE_W'($urandom));
    send_request(OP_PUSH, 8'hFF);
  endtask

  // new window size only takes effect after a clear
  task automatic test_window_latch();
    write_register(REG_WINDOW_SIZE, 17'd2);
    send_request(OP_PUSH, 8'h80);
    send_request(OP_PUSH, 8'h7F);
    send_request(OP_CLEAR, BYTE_W'($urandom));
    send_request(OP_PUSH, 8'h7F);
    send_request(OP_PUSH, 8'h7F);
    send_request(OP_PUSH, 8'h00);
  endtask

  // zero size taken as one, oversize taken as the ring depth
  task automatic test_window_limits();
    write_register(REG_WINDOW_SIZE, 17'd0);
    send_request(OP_CLEAR, BYTE_W'($urandom));
    send_request(OP_PUSH, 8'h7F);
    send_request(OP_PUSH, 8'h00);
    write_register(REG_WINDOW_SIZE, 17'h1FFFF);
    send_request(OP_CLEAR, BYTE_W'($urandom));
    send_request(OP_PUSH, 8'hFF);
  endtask

  // zero point, scale and cutoff at their ends, unsigned and then signed reading
  task automatic test_register_extremes();
    write_register(REG_WINDOW_SIZE, 17'd1);
    write_register(REG_OUTPUT_SIGNED, 17'd0);
    write_register(REG_ZERO_POINT, 17'h000FF);
    write_register(REG_SCALE, 17'd65535);
    write_register(REG_CUTOFF, 17'd0);
    send_request(OP_CLEAR, BYTE_W'($urandom));
    send_request(OP_PUSH, 8'h00);
    send_request(OP_PUSH, 8'hFF);
    write_register(REG_ZERO_POINT, 17'h00100);
    write_register(REG_CUTOFF, 17'd65536);
    send_request(OP_PUSH, 8'hFF);
    write_register(REG_CUTOFF, 17'h1FFFF);
    send_request(OP_PUSH, 8'h00);
    write_register(REG_SCALE, 17'd0);
    send_request(OP_PUSH, 8'h80);
    write_register(REG_OUTPUT_SIGNED, 17'h1FFFF);
    write_register(REG_SCALE, 17'd256);
    send_request(OP_PUSH, 8'h80);
  endtask

  // writes past the last register change nothing
  task automatic test_unused_registers();
    for (int k = int'(REG_WINDOW_SIZE) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_register(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    end
    send_request(OP_PUSH, BYTE_W'($urandom));
  endtask

  // one random setting, a clear, then a run of scores around a random level
  task automatic run_random_block(bit whole_ring, output int n_sent);
    int                n_items;
    int                clear_pct;
    int                centre;
    int                spread;
    int                v;
    int                pick;
    logic [BYTE_W-1:0] raw;
    if ($urandom_range(99) < 60) begin
      write_register(REG_OUTPUT_SIGNED, CFG_DATA_W'($urandom));
    end
    if ($urandom_range(99) < 60) begin
      pick = $urandom_range(9);
      case (pick)
        0:       write_register(REG_ZERO_POINT, 17'h00100);
        1:       write_register(REG_ZERO_POINT, 17'h000FF);
        2:       write_register(REG_ZERO_POINT, 17'h00180);
        default: write_register(REG_ZERO_POINT, CFG_DATA_W'($urandom));
      endcase
    end
    if ($urandom_range(99) < 60) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        write_register(REG_SCALE, 17'd0);
      end else if (pick == 1) begin
        write_register(REG_SCALE, 17'd65535);
      end else if (pick < 14) begin
        write_register(REG_SCALE, CFG_DATA_W'($urandom_range(64, 768)));
      end else begin
        write_register(REG_SCALE, CFG_DATA_W'($urandom));
      end
    end
    if ($urandom_range(99) < 60) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        write_register(REG_CUTOFF, 17'd0);
      end else if (pick == 1) begin
        write_register(REG_CUTOFF, 17'd65536);
      end else if (pick == 2) begin
        write_register(REG_CUTOFF, CFG_DATA_W'($urandom));
      end else begin
        write_register(REG_CUTOFF, CFG_DATA_W'($urandom_range(0, 65536)));
      end
    end
    // mostly short windows, now and then the whole ring, out of range or zero
    pick = $urandom_range(19);
    if (whole_ring || pick == 0) begin
      write_register(REG_WINDOW_SIZE, CFG_DATA_W'(WINDOW_DEPTH_DEF));
    end else if (pick == 1) begin
      write_register(REG_WINDOW_SIZE, CFG_DATA_W'($urandom_range(WINDOW_DEPTH_DEF + 1, 511)));
    end else if (pick == 2) begin
      write_register(REG_WINDOW_SIZE, 17'd0);
    end else begin
      write_register(REG_WINDOW_SIZE, CFG_DATA_W'($urandom_range(1, 12)));
    end
    send_request(OP_CLEAR, BYTE_W'($urandom));
    if (window_len >= 128) begin
      n_items   = window_len + $urandom_range(20, 80);
      clear_pct = 0;
    end else begin
      n_items   = $urandom_range(15, 60);
      clear_pct = 4;
    end
    centre = $urandom_range(0, 255);
    spread = $urandom_range(2, 64);
    for (int k = 0; k < n_items; k++) begin
      // sender pause until every result is back
      if ($urandom_range(99) == 0) begin
        wait_drain();
      end
      if ($urandom_range(99) < clear_pct) begin
        send_request(OP_CLEAR, BYTE_W'($urandom));
      end else begin
        if ($urandom_range(9) == 0) begin
          raw = BYTE_W'($urandom);
        end else begin
          v = centre + int'($urandom_range(0, 2 * spread)) - spread;
          if (v < 0) begin
            v = 0;
          end else if (v > 255) begin
            v = 255;
          end
          raw = BYTE_W'(v);
        end
        send_request(OP_PUSH, raw);
      end
    end
    n_sent = n_items + 1;
  endtask

  // random traffic under one idling pattern
  task automatic test_random_traffic(int s_pct, int r_pct, int budget, bit whole_ring_first);
    int sent;
    int n;
    bit first;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent  = 0;
    first = 1'b1;
    while (sent < budget) begin
      run_random_block(first && whole_ring_first, n);
      sent += n;
      first = 1'b0;
    end
  endtask

  // sequence of tests
  initial begin
    int guard;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_PUSH;
    in_score_byte = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 36;
    recv_idle_pct = 74;
    error_count   = 0;
    n_push        = 0;
    n_clear       = 0;
    n_detect      = 0;
    n_reg_writes  = 0;
    widest_window = 0;
    // predictor after reset
    sign_mode   = SIGNED_RST;
    zp_setting  = ZP_RST;
    scale_q16   = SCALE_RST;
    mean_cutoff = CUT_RST;
    window_reg  = WS_RST;
    foreach (prob_history[i]) prob_history[i] = 0;
    restart_window();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_clear_window();
    test_window_latch();
    test_window_limits();
    test_register_extremes();
    test_unused_registers();
    test_random_traffic(36, 74, 480, 1'b1);
    test_random_traffic(74, 36, 480, 1'b0);
    test_random_traffic(0, 0, 480, 1'b0);

    // drain and let the pipeline settle
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (pending_scores.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (pending_scores.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_scores.size()));
    end
    $display("covered %0d score pushes, %0d clears, %0d detections, %0d register writes",
             n_push, n_clear, n_detect, n_reg_writes);
    $display("widest window %0d; idling sender-heavy, receiver-heavy and none; %0d mismatches",
             widest_window, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
